// ----- src/cps_pkg.sv -----
// ----------------------------------------------------------------------------
// cps_pkg: shared types and constants of the polyline smoother
// Coordinate and item types, register indexes, ratio limits and the
// per-cell settings bundle.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int MAX_PASSES = 4;
  localparam int COORD_BITS = 32;
  localparam int PASS_W     = $clog2(MAX_PASSES + 1);
  localparam int PASS_REG_W = 3;
  localparam int W_BITS     = 16;
  localparam int RATIO_BITS = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [RATIO_BITS-1:0] RATIO_LO  = 15'd3277;
  localparam logic [RATIO_BITS-1:0] RATIO_HI  = 15'd29491;
  localparam logic [RATIO_BITS-1:0] RATIO_RST = 15'd16384;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_CLOSED = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATIO  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_PASSES = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    point_t pt;
    logic   last;
    logic   err;
  } item_t;

  // settings every cell sees; w_lo is the cut ratio, w_hi its complement
  typedef struct packed {
    logic              closed;
    logic [W_BITS-1:0] w_lo;
    logic [W_BITS-1:0] w_hi;
    logic              restart;
  } cell_cfg_t;

endpackage

// ----- src/chaikin_polyline_smoother.sv -----
// ----------------------------------------------------------------------------
// chaikin_polyline_smoother: streaming corner-cutting smoother
// Vertices enter one beat at a time and pass through a row of identical
// cells, one per smoothing pass; each cell cuts every segment in two.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_vx, in_vy, in_vz, in_vlast
//   out_    | output    | out_valid/out_stall | out_px, out_py, out_pz,
//           |           |                     | out_plast, out_too_few
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_addr, cfg_wdata
//
// Each cell issues one point per cycle from its op list while its output
// register is not held by a stall; a vertex yields 2^passes points at the
// last cell in steady state (16 at four passes), more for the closing vertex
// of a closed loop. Each cell passes a vertex through its op load, then its
// output register, in every cell of the row of four whatever the pass count.
// Reset is synchronous; it empties every cell and loads the register defaults.
// out_stall holds the last cell's output register and backs up cell by cell.
// ----------------------------------------------------------------------------
module chaikin_polyline_smoother import cps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_vx,
  input  logic [COORD_BITS-1:0] in_vy,
  input  logic [COORD_BITS-1:0] in_vz,
  input  logic                  in_vlast,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_px,
  output logic [COORD_BITS-1:0] out_py,
  output logic [COORD_BITS-1:0] out_pz,
  output logic                  out_plast,
  output logic                  out_too_few,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [W_BITS:0] W_ONE = (W_BITS + 1)'(1 << W_BITS);

  logic                  closed_r;
  logic [RATIO_BITS-1:0] ratio_r;
  logic [RATIO_BITS-1:0] ratio_nxt;
  logic [PASS_W-1:0]     passes_r;
  logic [PASS_W-1:0]     passes_nxt;
  logic [PASS_REG_W-1:0] pass_val;
  logic                  cfg_wr;
  cell_cfg_t             cell_cfg;

  item_t                 link       [MAX_PASSES+1];
  logic                  link_valid [MAX_PASSES+1];
  logic                  link_stall [MAX_PASSES+1];

  // configuration writes
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign pass_val  = cfg_wdata[PASS_REG_W-1:0];

  always_comb begin
    ratio_nxt = cfg_wdata[RATIO_BITS-1:0];
    if (ratio_nxt < RATIO_LO) begin
      ratio_nxt = RATIO_LO;
    end else if (ratio_nxt > RATIO_HI) begin
      ratio_nxt = RATIO_HI;
    end
  end

  always_comb begin
    if (pass_val == '0) begin
      passes_nxt = PASS_W'(1);
    end else if (int'(pass_val) > MAX_PASSES) begin
      passes_nxt = PASS_W'(MAX_PASSES);
    end else begin
      passes_nxt = PASS_W'(pass_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r <= 1'b0;
      ratio_r  <= RATIO_RST;
      passes_r <= PASS_W'(1);
    end else if (cfg_wr) begin
      case (cfg_addr)
        CFG_CLOSED: closed_r <= cfg_wdata[0];
        CFG_RATIO:  ratio_r  <= ratio_nxt;
        CFG_PASSES: passes_r <= passes_nxt;
        default:    ;
      endcase
    end
  end

  // settings shared by all cells
  assign cell_cfg.closed  = closed_r;
  assign cell_cfg.w_lo    = W_BITS'(ratio_r);
  assign cell_cfg.w_hi    = W_BITS'(W_ONE - (W_BITS + 1)'(ratio_r));
  assign cell_cfg.restart = cfg_wr && (cfg_addr == CFG_PASSES);

  // input beat into the head of the row
  assign link[0]       = {in_vx, in_vy, in_vz, in_vlast, 1'b0};
  assign link_valid[0] = in_valid;
  assign in_stall      = link_stall[0];

  // row of pass cells
  for (genvar s = 0; s < MAX_PASSES; s++) begin : g_cell
    cps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (cell_cfg),
      .en        (passes_r > PASS_W'(s)),
      .in_valid  (link_valid[s]),
      .in_stall  (link_stall[s]),
      .in_item   (link[s]),
      .out_valid (link_valid[s+1]),
      .out_stall (link_stall[s+1]),
      .out_item  (link[s+1])
    );
  end

  // result beat from the tail of the row
  assign link_stall[MAX_PASSES] = out_stall;
  assign out_valid   = link_valid[MAX_PASSES];
  assign out_px      = link[MAX_PASSES].pt.x;
  assign out_py      = link[MAX_PASSES].pt.y;
  assign out_pz      = link[MAX_PASSES].pt.z;
  assign out_plast   = link[MAX_PASSES].last;
  assign out_too_few = link[MAX_PASSES].err;

  // checks
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_few |->
      out_plast && (out_px == '0) && (out_py == '0) && (out_pz == '0))
    else $error("too_few result not a zero closing point");

  a_ratio_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_addr == CFG_RATIO) |=> (ratio_r >= RATIO_LO) && (ratio_r <= RATIO_HI))
    else $error("cut ratio outside clamp range");

  a_pass_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_addr == CFG_PASSES) |=>
      (passes_r >= PASS_W'(1)) && (int'(passes_r) <= MAX_PASSES))
    else $error("pass count outside clamp range");

endmodule

// ----- src/cps_mix.sv -----
// ----------------------------------------------------------------------------
// cps_mix: weighted blend of two points
// Computes (wp*P + wq*Q + half) >> 16 per coordinate, floor shift, with
// weights in unsigned Q0.16.
// ----------------------------------------------------------------------------
module cps_mix import cps_pkg::*; (
  input  point_t            p,
  input  point_t            q,
  input  logic [W_BITS-1:0] wp,
  input  logic [W_BITS-1:0] wq,
  output point_t            m
);

  localparam int PW = COORD_BITS + W_BITS + 1;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] HALF = SW'(1 << (W_BITS - 1));

  function automatic coord_t blend(coord_t a, coord_t b,
                                   logic [W_BITS-1:0] wa, logic [W_BITS-1:0] wb);
    logic signed [PW-1:0] pa;
    logic signed [PW-1:0] pb;
    logic signed [SW-1:0] s;
    pa = PW'($signed({1'b0, wa})) * PW'(a);
    pb = PW'($signed({1'b0, wb})) * PW'(b);
    s  = SW'(pa) + SW'(pb) + HALF;
    return s[W_BITS+COORD_BITS-1:W_BITS];
  endfunction

  // blend each axis on its own
  assign m.x = blend(p.x, q.x, wp, wq);
  assign m.y = blend(p.y, q.y, wp, wq);
  assign m.z = blend(p.z, q.z, wp, wq);

endmodule

// ----- src/cps_cell.sv -----
// ----------------------------------------------------------------------------
// cps_cell: one corner-cutting pass
// Takes an item, plans the points it yields into a short op list and
// issues one point per cycle into its output register while that register
// is not held by a stall. A disabled cell forwards each item unchanged.
// ----------------------------------------------------------------------------
module cps_cell import cps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cfg_t cfg,
  input  logic      en,
  input  logic      in_valid,
  output logic      in_stall,
  input  item_t     in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output item_t     out_item
);

  typedef enum logic [1:0] {OP_FIRST, OP_VERT, OP_ERR, OP_CUT} op_kind_t;
  typedef enum logic [1:0] {SEG_FH, SEG_HV, SEG_PV, SEG_VF} seg_t;

  typedef struct packed {
    op_kind_t kind;
    seg_t     seg;
    logic     hi;
    logic     last;
  } op_t;

  localparam int OPS_MAX = 6;
  localparam int OPN_W   = $clog2(OPS_MAX + 1);
  localparam int OPI_W   = $clog2(OPS_MAX);

  function automatic op_t mk_op(op_kind_t k, seg_t s, logic h, logic l);
    op_t o;
    o.kind = k;
    o.seg  = s;
    o.hi   = h;
    o.last = l;
    return o;
  endfunction

  // polyline state
  logic [1:0]       seen_r;
  logic [1:0]       seen_nxt;
  point_t           first_r;
  point_t           held_r;
  point_t           prev_r;

  // current job
  point_t           job_v_r;
  point_t           job_p_r;
  op_t              ops_r [OPS_MAX];
  logic [OPN_W-1:0] cnt_r;
  logic [OPN_W-1:0] idx_r;

  logic             out_valid_r;
  item_t            out_item_r;

  op_t              plan [OPS_MAX];
  logic [OPN_W-1:0] plan_n;

  logic             busy;
  logic             load_ok;
  logic             fire;
  logic             last_op;
  logic             accept;
  op_t              cur;
  point_t           mp;
  point_t           mq;
  point_t           mm;
  logic [W_BITS-1:0] wp;
  logic [W_BITS-1:0] wq;
  item_t            res;

  // handshake
  assign busy     = (idx_r != cnt_r);
  assign load_ok  = !out_valid_r || !out_stall;
  assign fire     = busy && load_ok;
  assign last_op  = (OPN_W'(idx_r + 1'b1) == cnt_r);
  assign in_stall = busy && !(fire && last_op);
  assign accept   = in_valid && !in_stall;

  // plan the points this item yields
  always_comb begin
    for (int i = 0; i < OPS_MAX; i++) begin
      plan[i] = mk_op(OP_ERR, SEG_FH, 1'b0, 1'b1);
    end
    plan_n   = '0;
    seen_nxt = seen_r;
    if (!en) begin
      plan_n = OPN_W'(1);
      if (!in_item.err) begin
        plan[0] = mk_op(OP_VERT, SEG_FH, 1'b0, in_item.last);
      end
    end else if (in_item.err) begin
      plan_n   = OPN_W'(1);
      seen_nxt = 2'd0;
    end else begin
      case (seen_r)
        2'd0: begin
          if (in_item.last) begin
            plan_n   = OPN_W'(1);
            seen_nxt = 2'd0;
          end else begin
            seen_nxt = 2'd1;
          end
        end
        2'd1: begin
          if (in_item.last) begin
            plan_n   = OPN_W'(1);
            seen_nxt = 2'd0;
          end else begin
            seen_nxt = 2'd2;
          end
        end
        2'd2: begin
          if (cfg.closed) begin
            plan[0] = mk_op(OP_CUT, SEG_FH, 1'b0, 1'b0);
            plan[1] = mk_op(OP_CUT, SEG_FH, 1'b1, 1'b0);
            plan[2] = mk_op(OP_CUT, SEG_HV, 1'b0, 1'b0);
            plan[3] = mk_op(OP_CUT, SEG_HV, 1'b1, 1'b0);
            plan[4] = mk_op(OP_CUT, SEG_VF, 1'b0, 1'b0);
            plan[5] = mk_op(OP_CUT, SEG_VF, 1'b1, 1'b1);
            plan_n  = in_item.last ? OPN_W'(6) : OPN_W'(4);
          end else begin
            plan[0] = mk_op(OP_FIRST, SEG_FH, 1'b0, 1'b0);
            plan[1] = mk_op(OP_CUT, SEG_FH, 1'b1, 1'b0);
            plan[2] = mk_op(OP_CUT, SEG_HV, 1'b0, 1'b0);
            plan[3] = in_item.last ? mk_op(OP_VERT, SEG_FH, 1'b0, 1'b1)
                                   : mk_op(OP_CUT, SEG_HV, 1'b1, 1'b0);
            plan_n  = OPN_W'(4);
          end
          seen_nxt = in_item.last ? 2'd0 : 2'd3;
        end
        default: begin
          if (cfg.closed) begin
            plan[0] = mk_op(OP_CUT, SEG_PV, 1'b0, 1'b0);
            plan[1] = mk_op(OP_CUT, SEG_PV, 1'b1, 1'b0);
            plan[2] = mk_op(OP_CUT, SEG_VF, 1'b0, 1'b0);
            plan[3] = mk_op(OP_CUT, SEG_VF, 1'b1, 1'b1);
            plan_n  = in_item.last ? OPN_W'(4) : OPN_W'(2);
          end else begin
            plan[0] = mk_op(OP_CUT, SEG_PV, 1'b0, 1'b0);
            plan[1] = in_item.last ? mk_op(OP_VERT, SEG_FH, 1'b0, 1'b1)
                                   : mk_op(OP_CUT, SEG_PV, 1'b1, 1'b0);
            plan_n  = OPN_W'(2);
          end
          seen_nxt = in_item.last ? 2'd0 : 2'd3;
        end
      endcase
    end
  end

  // pick the segment and weights of the current op
  assign cur = ops_r[idx_r[OPI_W-1:0]];

  always_comb begin
    case (cur.seg)
      SEG_FH: begin
        mp = first_r;
        mq = held_r;
      end
      SEG_HV: begin
        mp = held_r;
        mq = job_v_r;
      end
      SEG_PV: begin
        mp = job_p_r;
        mq = job_v_r;
      end
      default: begin
        mp = job_v_r;
        mq = first_r;
      end
    endcase
  end

  assign wp = cur.hi ? cfg.w_lo : cfg.w_hi;
  assign wq = cur.hi ? cfg.w_hi : cfg.w_lo;

  cps_mix u_mix (
    .p  (mp),
    .q  (mq),
    .wp (wp),
    .wq (wq),
    .m  (mm)
  );

  // form the outgoing point
  always_comb begin
    case (cur.kind)
      OP_FIRST: res.pt = first_r;
      OP_VERT:  res.pt = job_v_r;
      OP_CUT:   res.pt = mm;
      default:  res.pt = '0;
    endcase
    res.last = cur.last;
    res.err  = (cur.kind == OP_ERR);
  end

  // sequencer and polyline state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      if (accept) begin
        cnt_r <= plan_n;
        idx_r <= '0;
      end else if (fire) begin
        idx_r <= OPN_W'(idx_r + 1'b1);
      end
      // a pass count write restarts the polyline
      if (cfg.restart) begin
        seen_r <= 2'd0;
      end else if (accept && en) begin
        seen_r <= seen_nxt;
      end
    end
  end

  // capture vertices on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      ops_r   <= plan;
      job_v_r <= in_item.pt;
      job_p_r <= prev_r;
      if (en && !in_item.err) begin
        if (seen_r == 2'd0) begin
          first_r <= in_item.pt;
        end
        if (seen_r == 2'd1) begin
          held_r <= in_item.pt;
        end
        if (seen_r != 2'd0) begin
          prev_r <= in_item.pt;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_ok) begin
      out_valid_r <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- test/tb_chaikin_polyline_smoother.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chaikin_polyline_smoother: self-checking bench for the polyline smoother
// Streams open and closed polylines through the block under a sequence of
// register settings and handshake idling patterns. A local model of the
// cutting cells predicts every smoothed point, and each output beat is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_chaikin_polyline_smoother;
  import cps_pkg::*;

  localparam int     CELL_CAP = 3 << MAX_PASSES;  // points one cell may queue
  localparam int     SETTLE   = 40;               // cycles for the cells to go quiet
  localparam int     HOLD_LEN = 300;              // long receiver hold-off
  localparam int     PHASES   = 8;
  localparam coord_t C_MAX    = 32'sh7FFF_FFFF;
  localparam coord_t C_MIN    = 32'sh8000_0000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [COORD_BITS-1:0] in_vx = '0, in_vy = '0, in_vz = '0;
  logic                  in_vlast = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COORD_BITS-1:0] out_px, out_py, out_pz;
  logic                  out_plast, out_too_few;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow registers and per-cell state of the local model
  logic                  sh_closed = 1'b0;
  logic [RATIO_BITS-1:0] sh_ratio = RATIO_RST;
  logic [PASS_REG_W-1:0] sh_passes = 3'd1;
  point_t                first_pt [MAX_PASSES];
  point_t                held_pt  [MAX_PASSES];
  point_t                prev_pt  [MAX_PASSES];
  int                    seen_cnt [MAX_PASSES];

  item_t cell_src[$], cell_dst[$];
  item_t smoothed_q[$];   // predicted points, oldest first
  item_t vertex_q[$];     // vertices waiting for the driver
  item_t drv_item;

  bit in_acc = 1'b0;
  int send_gap_pct = 0, stall_pct = 0;
  int hold_asks = 0, hold_done = 0, hold_left = 0;
  int err_count = 0, vertices_sent = 0, points_checked = 0, too_few_seen = 0;

  chaikin_polyline_smoother dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local model of the cutting cells
  // ---------------------------------------------------------------------------
  function automatic coord_t blend(coord_t p, coord_t q, int w);
    longint acc;
    acc = longint'(65536 - w) * longint'(p) + longint'(w) * longint'(q) + 64'sd32768;
    acc = acc >>> 16;
    return acc[COORD_BITS-1:0];
  endfunction

  function automatic point_t blend_pt(point_t p, point_t q, int w);
    point_t r;
    r.x = blend(p.x, q.x, w);
    r.y = blend(p.y, q.y, w);
    r.z = blend(p.z, q.z, w);
    return r;
  endfunction

  function automatic void emit_pt(point_t p, logic last, logic err);
    item_t it;
    if (cell_dst.size() >= CELL_CAP) return;
    it.pt   = p;
    it.last = last;
    it.err  = err;
    cell_dst = {cell_dst, it};
  endfunction

  // emit the near cut point, the far one, or both, of segment p->q
  function automatic void emit_cut(point_t p, point_t q, int w, bit near_pt, bit far_pt,
                                   bit far_last);
    if (near_pt) emit_pt(blend_pt(p, q, w), 1'b0, 1'b0);
    if (far_pt) emit_pt(blend_pt(p, q, 65536 - w), far_last, 1'b0);
  endfunction

  function automatic void cut_cell(int s, item_t it, int w, bit closed);
    point_t zero_pt;
    zero_pt = '0;
    // pass an error straight on and restart the cell
    if (it.err) begin
      emit_pt(zero_pt, 1'b1, 1'b1);
      seen_cnt[s] = 0;
      return;
    end
    case (seen_cnt[s])
      0: begin
        first_pt[s] = it.pt;
        seen_cnt[s] = 1;
      end
      1: begin
        held_pt[s]  = it.pt;
        prev_pt[s]  = it.pt;
        seen_cnt[s] = 2;
      end
      2: begin
        if (closed) begin
          emit_cut(first_pt[s], held_pt[s], w, 1'b1, 1'b1, 1'b0);
          emit_cut(held_pt[s], it.pt, w, 1'b1, 1'b1, 1'b0);
        end else begin
          emit_pt(first_pt[s], 1'b0, 1'b0);
          emit_cut(first_pt[s], held_pt[s], w, 1'b0, 1'b1, 1'b0);
          emit_cut(held_pt[s], it.pt, w, 1'b1, !it.last, 1'b0);
        end
        seen_cnt[s] = 3;
      end
      default: emit_cut(prev_pt[s], it.pt, w, 1'b1, closed || !it.last, 1'b0);
    endcase
    if (seen_cnt[s] >= 2) prev_pt[s] = it.pt;
    // close the polyline: error if short, wrap cut if closed, end vertex if open
    if (it.last) begin
      if (seen_cnt[s] < 3) emit_pt(zero_pt, 1'b1, 1'b1);
      else if (closed) emit_cut(it.pt, first_pt[s], w, 1'b1, 1'b1, 1'b1);
      else emit_pt(it.pt, 1'b1, 1'b0);
      seen_cnt[s] = 0;
    end
  endfunction

  function automatic void smooth_vertex(item_t v);
    int passes, w;
    passes = sh_passes;
    w      = sh_ratio;
    if (passes < 1) passes = 1;
    if (passes > MAX_PASSES) passes = MAX_PASSES;
    if (w < RATIO_LO) w = RATIO_LO;
    if (w > RATIO_HI) w = RATIO_HI;
    cell_src.delete();
    cell_src = {cell_src, v};
    for (int s = 0; s < passes; s++) begin
      cell_dst.delete();
      foreach (cell_src[i]) cut_cell(s, cell_src[i], w, sh_closed);
      cell_src = cell_dst;
    end
    foreach (cell_src[i]) smoothed_q = {smoothed_q, cell_src[i]};
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and input acceptance, both sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    item_t want, v;
    in_acc = rst_n && in_valid && !in_stall;
    // compare an accepted output beat with the oldest prediction
    if (rst_n && out_valid && !out_stall) begin
      if (smoothed_q.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual x=%h y=%h z=%h last=%b err=%b",
                 $time, out_px, out_py, out_pz, out_plast, out_too_few);
        err_count++;
      end else begin
        want = smoothed_q.pop_front();
        check_field("px", want.pt.x, out_px);
        check_field("py", want.pt.y, out_py);
        check_field("pz", want.pt.z, out_pz);
        check_field("plast", 32'(want.last), 32'(out_plast));
        check_field("too_few", 32'(want.err), 32'(out_too_few));
        points_checked++;
        if (want.err) too_few_seen++;
      end
    end
    // predict the points caused by an accepted vertex
    if (in_acc) begin
      v.pt.x = in_vx;
      v.pt.y = in_vy;
      v.pt.z = in_vz;
      v.last = in_vlast;
      v.err  = 1'b0;
      smooth_vertex(v);
      vertices_sent++;
    end
  end

  // ---------------------------------------------------------------------------
  // Vertex driver: hold a stalled beat, otherwise advance or idle
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (vertex_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        drv_item = vertex_q.pop_front();
        in_vx    <= drv_item.pt.x;
        in_vy    <= drv_item.pt.y;
        in_vz    <= drv_item.pt.z;
        in_vlast <= drv_item.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_asks != hold_done) begin
      hold_left = HOLD_LEN;
      hold_done = hold_asks;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_vertex(coord_t x, coord_t y, coord_t z, logic last);
    item_t it;
    it.pt.x = x;
    it.pt.y = y;
    it.pt.z = z;
    it.last = last;
    it.err  = 1'b0;
    vertex_q = {vertex_q, it};
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $urandom();
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic void queue_polyline(int len, bit closes);
    for (int k = 0; k < len; k++)
      queue_vertex(rand_coord(), rand_coord(), rand_coord(), closes && (k == len - 1));
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 1;
    if (r < 15) return 2;
    if (r < 85) return $urandom_range(3, 6);
    return $urandom_range(7, 12);
  endfunction

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    // mirror the write in the shadow registers
    case (addr)
      CFG_CLOSED: sh_closed = data[0];
      CFG_RATIO:  sh_ratio = data[RATIO_BITS-1:0];
      CFG_PASSES: begin
        sh_passes = data[PASS_REG_W-1:0];
        foreach (seen_cnt[s]) seen_cnt[s] = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every vertex is taken and every predicted point has come out
  task automatic drain();
    while (vertex_q.size() != 0 || in_valid || smoothed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      1: begin send_gap_pct = 77; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 77; end
      3: begin send_gap_pct = 31; stall_pct = 31; end
      default: begin send_gap_pct = 0; stall_pct = 0; end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  // per phase settings: -1 leaves the register alone, -2 picks a random value
  int ph_closed [PHASES] = '{0, 1, 1, 0, 0, 1, -2, -2};
  int ph_ratio  [PHASES] = '{3277, 29491, 0, 32767, -2, -2, -2, -1};
  int ph_passes [PHASES] = '{2, 1, 4, 3, 0, 7, -1, -2};
  int ph_idle   [PHASES] = '{0, 1, 2, 3, 1, 3, 2, 0};

  initial begin
    int n;
    foreach (seen_cnt[s]) begin
      seen_cnt[s] = 0;
      first_pt[s] = '0;
      held_pt[s]  = '0;
      prev_pt[s]  = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: short polylines, coordinate extremes, open cuts
    set_idling(0);
    queue_vertex(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b1);
    queue_vertex(C_MAX, C_MIN, '0, 1'b0);
    queue_vertex(C_MIN, C_MAX, '1, 1'b1);
    queue_vertex(C_MAX, C_MIN, '0, 1'b0);
    queue_vertex(C_MIN, C_MAX, '1, 1'b0);
    queue_vertex('0, '1, C_MAX, 1'b0);
    queue_vertex('1, '0, C_MIN, 1'b1);
    queue_vertex('0, '0, '0, 1'b0);
    queue_vertex(32'sh000A_0000, '0, 32'sh0000_8000, 1'b0);
    queue_vertex(32'sh000A_0000, 32'sh000A_0000, -32'sh0000_8000, 1'b1);
    drain();

    // directed, closed loops including wrap cut and a short one
    write_reg(CFG_CLOSED, 15'd1);
    queue_vertex('0, '0, '0, 1'b0);
    queue_vertex(32'sh0010_0000, '0, '0, 1'b0);
    queue_vertex(32'sh0010_0000, 32'sh0010_0000, '0, 1'b1);
    queue_vertex(C_MAX, C_MAX, C_MAX, 1'b0);
    queue_vertex(C_MIN, C_MIN, C_MIN, 1'b1);
    queue_polyline(4, 1'b1);
    queue_polyline(5, 1'b1);
    // leave a polyline open so the next pass count write must restart it
    queue_polyline(2, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (ph_closed[p] != -1)
        write_reg(CFG_CLOSED,
                  CFG_DATA_W'((ph_closed[p] == -2) ? $urandom_range(0, 1) : ph_closed[p]));
      if (ph_ratio[p] != -1)
        write_reg(CFG_RATIO,
                  CFG_DATA_W'((ph_ratio[p] == -2) ? $urandom_range(RATIO_LO, RATIO_HI)
                                                  : ph_ratio[p]));
      if (ph_passes[p] != -1)
        write_reg(CFG_PASSES,
                  CFG_DATA_W'((ph_passes[p] == -2) ? $urandom_range(1, MAX_PASSES)
                                                   : ph_passes[p]));
      set_idling(ph_idle[p]);
      n = 0;
      while (n < 28) begin
        int len;
        len = rand_len();
        queue_polyline(len, 1'b1);
        n += len;
      end
      // sometimes end the phase inside a polyline
      if ($urandom_range(0, 99) < 35) queue_polyline($urandom_range(1, 4), 1'b0);
      // fill the block behind a long hold-off on the output
      if (ph_idle[p] == 2 && p < 4) hold_asks++;
      drain();
    end

    $display("Sent %0d vertices through %0d register settings under four idling patterns.",
             vertices_sent, PHASES + 2);
    $display("Checked %0d smoothed points, %0d of them short-polyline errors.",
             points_checked, too_few_seen);
    if (err_count == 0) begin
      $display("tb_chaikin_polyline_smoother passed");
    end else begin
      $display("tb_chaikin_polyline_smoother failed");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Timeout with %0d points still expected.", smoothed_q.size());
    $display("tb_chaikin_polyline_smoother failed");
    $finish;
  end

endmodule
